// ===== rtl/core/base64_line_wrapped_encoder_assert.svh =====
// Assertion macros used by the checker file.
`ifndef BASE64_LINE_WRAPPED_ENCODER_ASSERT_SVH
`define BASE64_LINE_WRAPPED_ENCODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define B64E_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed in base64 encoder");

// Consequent must hold in the cycle after the antecedent.
`define B64E_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed in base64 encoder");

`endif

// ===== rtl/core/b64e_pkg.sv =====
package b64e_pkg;

	localparam int B64E_MAX_CHARS   = 6;
	localparam int B64E_QUEUE_DEPTH = 4;
	localparam int B64E_PADDR_W     = 3;
	localparam int B64E_PDATA_W     = 32;

	localparam logic [5:0] B64E_GPL_RESET = 6'd19;

	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_PAD = 8'h3D;

	// register numbers on the configuration port
	localparam logic REG_GROUPS_PER_LINE = 1'b0;

	typedef enum logic [1:0] {
		PH_EMPTY,
		PH_ONE,
		PH_TWO
	} b64e_phase_t;

	typedef struct packed {
		logic [B64E_MAX_CHARS-1:0][7:0] chars;
		logic [2:0]                     num_chars;
		logic                           last;
	} b64e_job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} b64e_qstat_t;

	// standard alphabet: A-Z a-z 0-9 + /
	function automatic logic [7:0] b64e_sym(input logic [5:0] six);
		logic [7:0] s;
		s = {2'b00, six};
		if (six < 6'd26)
			return 8'h41 + s;
		else if (six < 6'd52)
			return 8'h61 + s - 8'd26;
		else if (six < 6'd62)
			return 8'h30 + s - 8'd52;
		else if (six == 6'd62)
			return 8'h2B;
		else
			return 8'h2F;
	endfunction

endpackage

// ===== rtl/core/b64e_front.sv =====
module b64e_front
	import b64e_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        data_valid,
	output logic        data_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_of_data,
	input  logic [5:0]  groups_per_line,
	input  b64e_qstat_t qstat,
	output logic        push,
	output b64e_job_t   push_job
);

	b64e_phase_t phase_q, phase_next;
	logic [15:0] pend_q;
	logic [5:0]  groups_q;
	logic [5:0]  groups_inc;
	logic        accept;
	logic        line_break;
	logic [7:0]  b1, b2;

	assign data_stall = qstat.full;
	assign accept     = data_valid && !qstat.full;
	assign groups_inc = groups_q + 6'd1;
	assign line_break = (groups_inc == groups_per_line);

	always_comb begin
		phase_next = phase_q;
		if (accept) begin
			case (phase_q)
				PH_EMPTY: phase_next = end_of_data ? PH_EMPTY : PH_ONE;
				PH_ONE:   phase_next = end_of_data ? PH_EMPTY : PH_TWO;
				PH_TWO:   phase_next = PH_EMPTY;
				default:  phase_next = PH_EMPTY;
			endcase
		end
	end

	always_comb begin
		b1       = (phase_q == PH_TWO) ? pend_q[15:8] : pend_q[7:0];
		b2       = pend_q[7:0];
		push     = 1'b0;
		push_job = '0;
		push_job.last = end_of_data;
		case (phase_q)
			PH_EMPTY: begin
				push                = accept && end_of_data;
				push_job.chars[0]   = b64e_sym(data_byte[7:2]);
				push_job.chars[1]   = b64e_sym({data_byte[1:0], 4'b0000});
				push_job.chars[2]   = CH_PAD;
				push_job.chars[3]   = CH_PAD;
				push_job.num_chars  = 3'd4;
			end
			PH_ONE: begin
				push                = accept && end_of_data;
				push_job.chars[0]   = b64e_sym(b1[7:2]);
				push_job.chars[1]   = b64e_sym({b1[1:0], data_byte[7:4]});
				push_job.chars[2]   = b64e_sym({data_byte[3:0], 2'b00});
				push_job.chars[3]   = CH_PAD;
				push_job.num_chars  = 3'd4;
			end
			PH_TWO: begin
				push                = accept;
				push_job.chars[0]   = b64e_sym(b1[7:2]);
				push_job.chars[1]   = b64e_sym({b1[1:0], b2[7:4]});
				push_job.chars[2]   = b64e_sym({b2[3:0], data_byte[7:6]});
				push_job.chars[3]   = b64e_sym(data_byte[5:0]);
				push_job.chars[4]   = CH_CR;
				push_job.chars[5]   = CH_LF;
				push_job.num_chars  = line_break ? 3'd6 : 3'd4;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_EMPTY;
			groups_q <= '0;
		end else begin
			phase_q <= phase_next;
			if (accept) begin
				if (end_of_data)
					groups_q <= '0;
				else if (phase_q == PH_TWO)
					groups_q <= line_break ? 6'd0 : groups_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !end_of_data) begin
			if (phase_q == PH_EMPTY)
				pend_q <= {8'h00, data_byte};
			else if (phase_q == PH_ONE)
				pend_q <= {pend_q[7:0], data_byte};
		end
	end

endmodule

// ===== rtl/core/b64e_fifo.sv =====
module b64e_fifo
	import b64e_pkg::*;
#(
	parameter int DEPTH = B64E_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  b64e_job_t   push_job,
	input  logic        pop,
	output b64e_job_t   pop_job,
	output b64e_qstat_t qstat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	b64e_job_t      slots_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign qstat.full  = (count_q == CW'(DEPTH));
	assign qstat.empty = (count_q == '0);
	assign pop_job     = slots_q[rd_ptr_q];

	function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= bump(wr_ptr_q);
			if (pop)
				rd_ptr_q <= bump(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slots_q[wr_ptr_q] <= push_job;
	end

endmodule

// ===== rtl/core/b64e_back.sv =====
module b64e_back
	import b64e_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  b64e_qstat_t qstat,
	input  b64e_job_t   pop_job,
	output logic        pop,
	output logic        char_valid,
	input  logic        char_stall,
	output logic [7:0]  out_char,
	output logic        last_char
);

	b64e_job_t  job_q;
	logic       job_valid_q;
	logic [2:0] idx_q;
	logic       advance;
	logic       job_done;

	assign advance  = !char_valid || !char_stall;
	assign job_done = job_valid_q && advance && (idx_q == job_q.num_chars - 3'd1);
	// refill the job register when it is empty or its final char is leaving
	assign pop      = !qstat.empty && (!job_valid_q || job_done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			idx_q       <= '0;
			char_valid  <= 1'b0;
		end else begin
			if (advance)
				char_valid <= job_valid_q;
			if (pop) begin
				job_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (job_done) begin
				job_valid_q <= 1'b0;
				idx_q       <= '0;
			end else if (job_valid_q && advance) begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			job_q <= pop_job;
		if (advance && job_valid_q) begin
			out_char  <= job_q.chars[idx_q];
			last_char <= job_q.last && (idx_q == job_q.num_chars - 3'd1);
		end
	end

endmodule

// ===== rtl/core/base64_line_wrapped_encoder.sv =====
// Base64 encoder with CR LF line wrapping. Send one raw byte per request on the data
// channel, with end_of_data set on the final byte of a message; characters leave one per
// cycle on the char channel while char_stall is low, last_char marking the final one.
// Every third byte yields four alphabet characters, followed by CR LF once groups_per_line
// groups (register at address 0, reset 19, i.e. 76 columns) fill a line; a short final
// group is padded with "=" or "==". The group count of a line restarts with each message.
// A byte is taken in any cycle while the job queue between the byte front end and the
// character serializer has room, so bursts of up to QUEUE_DEPTH groups enter at one byte
// per cycle. Sustained throughput is set by the single-character output register: a full
// group of 3 bytes yields 4 characters, or 6 when it closes a line, and a padded final
// group yields 4 characters for its one or two bytes. The first character of a group
// passes through the job queue, the job register and the output register after its
// completing byte is accepted.
module base64_line_wrapped_encoder
	import b64e_pkg::*;
#(
	parameter int QUEUE_DEPTH = B64E_QUEUE_DEPTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [B64E_PADDR_W-1:0] paddr,
	input  logic [B64E_PDATA_W-1:0] pwdata,
	output logic [B64E_PDATA_W-1:0] prdata,
	output logic                    pready,
	input  logic                    data_valid,
	output logic                    data_stall,
	input  logic [7:0]              data_byte,
	input  logic                    end_of_data,
	output logic                    char_valid,
	input  logic                    char_stall,
	output logic [7:0]              out_char,
	output logic                    last_char
);

	logic [5:0]  gpl_q;
	logic        reg_hit;
	b64e_qstat_t qstat;
	logic        push, pop;
	b64e_job_t   push_job, pop_job;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[B64E_PADDR_W-1] == REG_GROUPS_PER_LINE);
	assign prdata  = reg_hit ? {{(B64E_PDATA_W-6){1'b0}}, gpl_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			gpl_q <= B64E_GPL_RESET;
		else if (psel && penable && pwrite && pready && reg_hit)
			gpl_q <= pwdata[5:0];
	end

	b64e_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.data_valid      (data_valid),
		.data_stall      (data_stall),
		.data_byte       (data_byte),
		.end_of_data     (end_of_data),
		.groups_per_line (gpl_q),
		.qstat           (qstat),
		.push            (push),
		.push_job        (push_job)
	);

	b64e_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.pop_job  (pop_job),
		.qstat    (qstat)
	);

	b64e_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.qstat      (qstat),
		.pop_job    (pop_job),
		.pop        (pop),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.out_char   (out_char),
		.last_char  (last_char)
	);

endmodule

// ===== rtl/core/b64e_checker.sv =====
`include "base64_line_wrapped_encoder_assert.svh"

module b64e_checker
	import b64e_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       char_valid,
	input logic       char_stall,
	input logic [7:0] out_char,
	input logic       last_char
);

	logic legal_char;

	assign legal_char = (out_char >= 8'h41 && out_char <= 8'h5A) ||
		(out_char >= 8'h61 && out_char <= 8'h7A) ||
		(out_char >= 8'h30 && out_char <= 8'h39) ||
		out_char == 8'h2B || out_char == 8'h2F ||
		out_char == CH_PAD || out_char == CH_CR || out_char == CH_LF;

	`B64E_ASSERT_NEXT(a_hold_stalled, clk, arst_n, char_valid && char_stall, char_valid && $stable(out_char) && $stable(last_char))
	`B64E_ASSERT_SAME(a_legal_char, clk, arst_n, char_valid, legal_char)
	`B64E_ASSERT_SAME(a_cr_not_last, clk, arst_n, char_valid && out_char == CH_CR, !last_char)
	`B64E_ASSERT_NEXT(a_lf_after_cr, clk, arst_n, char_valid && !char_stall && out_char == CH_CR, char_valid && out_char == CH_LF)

endmodule

bind base64_line_wrapped_encoder b64e_checker u_b64e_checker (.*);

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import b64e_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_OFF_CYCLES = 80;
	localparam logic [B64E_PADDR_W-1:0] ADDR_GROUPS_PER_LINE = {REG_GROUPS_PER_LINE, 2'b00};
	// register index 1 does not exist
	localparam logic [B64E_PADDR_W-1:0] ADDR_UNMAPPED = 3'd4;
	localparam logic [8*64-1:0] ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	typedef struct packed {
		logic [7:0] data;
		logic       fin;
	} byte_req_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       is_last;
	} char_exp_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    psel = 1'b0;
	logic                    penable = 1'b0;
	logic                    pwrite = 1'b0;
	logic [B64E_PADDR_W-1:0] paddr = '0;
	logic [B64E_PDATA_W-1:0] pwdata = '0;
	logic [B64E_PDATA_W-1:0] prdata;
	logic                    pready;
	logic                    data_valid = 1'b0;
	logic                    data_stall;
	logic [7:0]              data_byte = 8'h00;
	logic                    end_of_data = 1'b0;
	logic                    char_valid;
	logic                    char_stall = 1'b0;
	logic [7:0]              out_char;
	logic                    last_char;

	byte_req_t byte_req_q[$];
	char_exp_t encoded_chars_q[$];

	// encoder state as predicted
	logic [5:0]  line_len = B64E_GPL_RESET;
	logic [15:0] held_bytes = '0;
	b64e_phase_t held_count = PH_EMPTY;
	logic [5:0]  groups_on_line = '0;

	int fail_count = 0;
	int bytes_queued = 0;
	int bytes_accepted = 0;
	int messages_queued = 0;
	int chars_checked = 0;
	int line_breaks = 0;
	int cycles = 0;
	int send_idle_pct = 34;
	int recv_idle_pct = 34;
	int hold_requests = 0;
	int holds_started = 0;
	int hold_left = 0;

	base64_line_wrapped_encoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.data_valid (data_valid),
		.data_stall (data_stall),
		.data_byte  (data_byte),
		.end_of_data(end_of_data),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.out_char   (out_char),
		.last_char  (last_char)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	function automatic logic [7:0] b64_symbol(input logic [5:0] six);
		return ALPHABET[8 * (63 - int'(six)) +: 8];
	endfunction

	task automatic encode_accepted_byte(input logic [7:0] b, input logic fin);
		logic [7:0] chars[6];
		logic [7:0] b1;
		logic [7:0] b2;
		char_exp_t exp_ch;
		int n;
		n = 0;
		case (held_count)
			PH_EMPTY: begin
				if (fin) begin
					chars[0] = b64_symbol(b[7:2]);
					chars[1] = b64_symbol({b[1:0], 4'b0000});
					chars[2] = CH_PAD;
					chars[3] = CH_PAD;
					n = 4;
				end else begin
					held_bytes = {8'h00, b};
					held_count = PH_ONE;
				end
			end
			PH_ONE: begin
				b1 = held_bytes[7:0];
				if (fin) begin
					chars[0] = b64_symbol(b1[7:2]);
					chars[1] = b64_symbol({b1[1:0], b[7:4]});
					chars[2] = b64_symbol({b[3:0], 2'b00});
					chars[3] = CH_PAD;
					n = 4;
				end else begin
					held_bytes = {b1, b};
					held_count = PH_TWO;
				end
			end
			default: begin
				b1 = held_bytes[15:8];
				b2 = held_bytes[7:0];
				chars[0] = b64_symbol(b1[7:2]);
				chars[1] = b64_symbol({b1[1:0], b2[7:4]});
				chars[2] = b64_symbol({b2[3:0], b[7:6]});
				chars[3] = b64_symbol(b[5:0]);
				n = 4;
				groups_on_line = groups_on_line + 6'd1;
				if (groups_on_line == line_len) begin
					chars[4] = CH_CR;
					chars[5] = CH_LF;
					n = 6;
					groups_on_line = '0;
				end
				held_bytes = '0;
				held_count = PH_EMPTY;
			end
		endcase
		// a message always ends with an empty buffer and a restarted line group count
		if (fin) begin
			held_bytes = '0;
			held_count = PH_EMPTY;
			groups_on_line = '0;
		end
		for (int i = 0; i < n; i++) begin
			exp_ch.ch = chars[i];
			exp_ch.is_last = fin && (i == n - 1);
			encoded_chars_q.insert(encoded_chars_q.size(), exp_ch);
		end
	endtask

	always @(posedge clk) begin : byte_sender
		byte_req_t nxt;
		if (arst_n) begin
			if (data_valid && !data_stall) begin
				encode_accepted_byte(data_byte, end_of_data);
				bytes_accepted++;
			end
			if (!data_valid || !data_stall) begin
				if (byte_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = byte_req_q.pop_front();
					data_valid <= 1'b1;
					data_byte <= nxt.data;
					end_of_data <= nxt.fin;
				end else begin
					data_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : char_receiver
		char_exp_t want;
		logic stall_next;
		if (arst_n) begin
			if (char_valid && !char_stall) begin
				if (encoded_chars_q.size() == 0) begin
					$error("unexpected character 0x%02h (last_char %0b)", out_char, last_char);
					fail_count++;
				end else begin
					want = encoded_chars_q.pop_front();
					chars_checked++;
					if (out_char == CH_LF)
						line_breaks++;
					if (out_char !== want.ch) begin
						$error("out_char: expected 0x%02h, got 0x%02h", want.ch, out_char);
						fail_count++;
					end
					if (last_char !== want.is_last) begin
						$error("last_char: expected %0b, got %0b", want.is_last, last_char);
						fail_count++;
					end
				end
			end
			if (hold_requests != holds_started) begin
				holds_started++;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				stall_next = 1'b1;
			end else begin
				stall_next = $urandom_range(99) < recv_idle_pct;
			end
			char_stall <= stall_next;
		end
	end

	task automatic push_byte(input logic [7:0] data, input logic fin);
		byte_req_t req;
		req.data = data;
		req.fin = fin;
		byte_req_q.insert(byte_req_q.size(), req);
		bytes_queued++;
		if (fin)
			messages_queued++;
	endtask

	task automatic queue_message(input int len, input logic with_fin);
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(7) == 0)
				b = $urandom_range(1) ? 8'hFF : 8'h00;
			else
				b = 8'($urandom);
			push_byte(b, with_fin && (i == len - 1));
		end
	endtask

	task automatic queue_traffic(input int n_bytes);
		int len;
		while (n_bytes > 0) begin
			// mostly short messages, now and then one spanning a few lines
			if ($urandom_range(5) == 0)
				len = $urandom_range(60, 1);
			else
				len = $urandom_range(12, 1);
			if (len > n_bytes)
				len = n_bytes;
			queue_message(len, 1'b1);
			n_bytes -= len;
		end
	endtask

	task automatic drain_and_settle();
		while (bytes_accepted != bytes_queued)
			@(posedge clk);
		while (encoded_chars_q.size() != 0)
			@(posedge clk);
		// a buffered byte gives no output, so let the pipeline go quiet
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input logic [B64E_PADDR_W-1:0] addr, input logic [5:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= {26'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == ADDR_GROUPS_PER_LINE)
			line_len = value;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic check_line_len_reg();
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_GROUPS_PER_LINE;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {26'd0, line_len}) begin
			$error("groups_per_line: expected 0x%08h, got 0x%08h", {26'd0, line_len}, prdata);
			fail_count++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_line_len(input logic [5:0] value);
		reg_write(ADDR_GROUPS_PER_LINE, value);
		check_line_len_reg();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset line length: messages of one, two, three and four bytes
		check_line_len_reg();
		push_byte(8'hFF, 1'b1);
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b1);
		push_byte(8'hFB, 1'b0);
		push_byte(8'hEF, 1'b0);
		push_byte(8'hBE, 1'b1);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b1);
		drain_and_settle();

		// one group per line: break after every full group, also at message end, none after a padded one
		set_line_len(6'd1);
		reg_write(ADDR_UNMAPPED, 6'd7);
		check_line_len_reg();
		push_byte(8'h00, 1'b0);
		push_byte(8'h10, 1'b0);
		push_byte(8'h83, 1'b0);
		push_byte(8'h10, 1'b0);
		push_byte(8'h51, 1'b0);
		push_byte(8'h87, 1'b1);
		push_byte(8'h80, 1'b0);
		push_byte(8'h01, 1'b1);
		push_byte(8'h4D, 1'b0);
		push_byte(8'h61, 1'b0);
		push_byte(8'h6E, 1'b0);
		push_byte(8'h7F, 1'b1);
		drain_and_settle();

		set_line_len(6'd63);
		queue_traffic(70);
		drain_and_settle();

		// cut the line length below the running count, down to zero: counter must wrap
		set_line_len(6'd3);
		queue_message(6, 1'b0);
		drain_and_settle();
		set_line_len(6'd0);
		queue_message(186, 1'b1);
		drain_and_settle();

		// no idling, with a long output hold-off so the input backs up
		set_line_len(6'd19);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_requests++;
		queue_traffic(100);
		drain_and_settle();
		send_idle_pct = 34;
		recv_idle_pct = 34;

		repeat (3) begin
			set_line_len(6'($urandom_range(8, 1)));
			queue_traffic(40);
			drain_and_settle();
		end

		if (encoded_chars_q.size() != 0) begin
			$error("%0d expected characters never arrived", encoded_chars_q.size());
			fail_count++;
		end
		$display("Encoded %0d messages (%0d bytes) into %0d checked characters, %0d line breaks.",
			messages_queued, bytes_accepted, chars_checked, line_breaks);
		$display("Line lengths 19, 1, 63, 0 and random, a mid-line cut and an output hold-off.");
		if (fail_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
